>>> src/rwc_pkg.sv
// Shared types and constants for the RGB window convolution block.
// No dependencies; imported by every module of the block.
package rwc_pkg;

	localparam int unsigned DEF_MAX_WIDTH  = 1024;
	localparam int unsigned DEF_MAX_RADIUS = 7;
	localparam int unsigned PIX_W          = 8;
	localparam int unsigned APB_AW         = 5;

	localparam logic [10:0] RST_WIDTH  = 11'd640;
	localparam logic [15:0] RST_HEIGHT = 16'd480;
	localparam logic [2:0]  RST_RADIUS = 3'd1;
	localparam logic [11:0] RST_CW     = 12'd1;
	localparam logic [11:0] RST_OW     = 12'd1;

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_RADIUS = 3'd2,
		REG_CW     = 3'd3,
		REG_OW     = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_MUL,
		ST_SUM,
		ST_START,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

>>> src/rwc_div.sv
// Signed divide of a weighted sum by the mask sum, truncated and clamped to 0..255.
// One quotient bit per cycle, from bit 7 down to bit 0; a saturated result is held
// through the iterations so every channel finishes together. Uses rwc_pkg.
module rwc_div #(
	parameter int unsigned NW = 30,
	parameter int unsigned DW = 22
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NW-1:0]    num,
	input  logic signed [DW-1:0]    den,
	output logic [rwc_pkg::PIX_W-1:0] quo,
	output logic                    done
);
	import rwc_pkg::*;

	localparam int unsigned CW = ((NW > DW + 8) ? NW : DW + 8) + 1;

	logic          act_q, done_q, sat_q;
	logic [2:0]    k_q;
	logic [CW-1:0] rem_q, dmag_q, shd;
	logic [PIX_W-1:0] quo_q;
	logic [NW-1:0] nabs;
	logic [DW-1:0] dabs;
	logic          num_neg, den_neg, ge;

	assign num_neg = num[NW-1];
	assign den_neg = den[DW-1];
	assign nabs    = num_neg ? NW'(-num) : NW'(num);
	assign dabs    = den_neg ? DW'(-den) : DW'(den);
	assign shd     = dmag_q << k_q;
	assign ge      = rem_q >= shd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				act_q <= 1'b1;
			end else if (act_q && k_q == 3'd0) begin
				act_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= CW'(nabs);
			dmag_q <= CW'(dabs);
			k_q    <= 3'd7;
			sat_q  <= (num_neg != den_neg) || (CW'(nabs) >= (CW'(dabs) << 8));
			if (num_neg != den_neg) begin
				quo_q <= '0;
			end else if (CW'(nabs) >= (CW'(dabs) << 8)) begin
				quo_q <= '1;
			end else begin
				quo_q <= '0;
			end
		end else if (act_q) begin
			// hold a saturated quotient while the count runs down
			if (ge && !sat_q) begin
				rem_q      <= rem_q - shd;
				quo_q[k_q] <= 1'b1;
			end
			k_q <= k_q - 3'd1;
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |=> !done)
		else $error("divider done in the cycle after start");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !act_q)
		else $error("divider done while still iterating");
	assert property (@(posedge clk) disable iff (!arst_n) (act_q && k_q != 3'd0) |=> act_q)
		else $error("divider stopped early");

endmodule

>>> src/rgb_window_convolution_replicate.sv
// RGB window convolution with replicated borders, top level.
// Each output pixel takes a pass through the read, wait, multiply, sum, start, divide
// and output states; an item that emits n pixels keeps the input stalled for n such
// passes. Rate is set by the single read port of the line store, read once per window tap.
// Reset clears control state and loads the register defaults; the line store is
// not cleared, as only rows written in the current image are ever read.
module rgb_window_convolution_replicate #(
	parameter int unsigned MAX_WIDTH  = rwc_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_RADIUS = rwc_pkg::DEF_MAX_RADIUS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rwc_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [rwc_pkg::PIX_W-1:0]   red,
	input  logic [rwc_pkg::PIX_W-1:0]   green,
	input  logic [rwc_pkg::PIX_W-1:0]   blue,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rwc_pkg::PIX_W-1:0]   out_red,
	output logic [rwc_pkg::PIX_W-1:0]   out_green,
	output logic [rwc_pkg::PIX_W-1:0]   out_blue,
	output logic                        last_in_run,
	output logic                        frame_end
);
	import rwc_pkg::*;

	localparam int unsigned LINE_ROWS = 2 * MAX_RADIUS + 1;
	localparam int unsigned RW   = $clog2(LINE_ROWS);
	localparam int unsigned COLW = $clog2(MAX_WIDTH);
	localparam int unsigned XW   = COLW + 1;
	localparam int unsigned YW   = 17;
	localparam int unsigned WIN_MAX = LINE_ROWS * LINE_ROWS;
	localparam int unsigned SUMW = $clog2(WIN_MAX * 255 + 1);
	localparam int unsigned DDW  = $clog2(WIN_MAX);
	localparam int unsigned MSW  = DDW + 14;
	localparam int unsigned PAW  = SUMW + 13;
	localparam int unsigned PBW  = 22;
	localparam int unsigned NW   = SUMW + 14;
	localparam int unsigned DEPTH = (1 << RW) * (1 << COLW);

	// configuration registers
	logic [10:0] width_q;
	logic [15:0] height_q;
	logic [2:0]  radius_q;
	logic [11:0] cw_q, ow_q;
	logic        cfg_wr;
	reg_idx_t    cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			radius_q <= RST_RADIUS;
			cw_q     <= RST_CW;
			ow_q     <= RST_OW;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_WIDTH:  width_q  <= pwdata[10:0];
				REG_HEIGHT: height_q <= pwdata[15:0];
				REG_RADIUS: radius_q <= pwdata[2:0];
				REG_CW:     cw_q     <= pwdata[11:0];
				REG_OW:     ow_q     <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			REG_RADIUS: prdata = 32'(radius_q);
			REG_CW:     prdata = 32'(cw_q);
			REG_OW:     prdata = 32'(ow_q);
			default:    prdata = '0;
		endcase
	end

	// effective geometry
	logic [XW-1:0] w_eff;
	logic [YW-1:0] h_eff;
	logic [RW-1:0] r_eff;
	logic [RW:0]   d_eff;

	always_comb begin
		if (width_q == 11'd0) begin
			w_eff = XW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = XW'(MAX_WIDTH);
		end else begin
			w_eff = XW'(width_q);
		end
		h_eff = (height_q == 16'd0) ? YW'(1) : YW'(height_q);
		r_eff = (32'(radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_q);
		d_eff = {r_eff, 1'b1};
	end

	// mask sum, refreshed every cycle from the registers
	logic [DDW-1:0]        ddm1_q;
	logic signed [MSW-1:0] msum_q;
	logic signed [MSW-1:0] msum_raw;

	assign msum_raw = MSW'($signed(ow_q) * $signed({1'b0, ddm1_q})) + MSW'($signed(cw_q));

	always_ff @(posedge clk) begin
		ddm1_q <= DDW'(DDW'(d_eff) * DDW'(d_eff) - 1'b1);
		msum_q <= (msum_raw == '0) ? MSW'(1) : msum_raw;
	end

	// position counters
	state_t        state_q, state_d;
	logic [COLW-1:0] cx_q;
	logic [YW-1:0]   cy_q;
	logic [RW-1:0]   slot_q;
	logic [COLW-1:0] cx;
	logic            accept, last_col, frame_done, emit_any;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign cx       = (XW'(cx_q) >= w_eff) ? COLW'(w_eff - 1'b1) : cx_q;
	assign last_col = (XW'(cx) == w_eff - 1'b1);
	assign frame_done = last_col && (cy_q == h_eff + YW'(r_eff) - 1'b1);
	assign emit_any = (cy_q >= YW'(r_eff)) && (last_col || XW'(cx) >= XW'(r_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q   <= '0;
			cy_q   <= '0;
			slot_q <= '0;
		end else if (cfg_wr && (cfg_idx inside {REG_WIDTH, REG_HEIGHT, REG_RADIUS,
				REG_CW, REG_OW})) begin
			cx_q   <= '0;
			cy_q   <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (frame_done) begin
				cx_q   <= '0;
				cy_q   <= '0;
				slot_q <= '0;
			end else if (last_col) begin
				cx_q   <= '0;
				cy_q   <= cy_q + 1'b1;
				slot_q <= (32'(slot_q) == LINE_ROWS - 1) ? '0 : slot_q + 1'b1;
			end else begin
				cx_q <= cx + 1'b1;
			end
		end
	end

	// per-item work registers
	logic [COLW-1:0] x_q, x_end_q;
	logic [YW-1:0]   y_q, cyw_q;
	logic [RW-1:0]   wslot_q;
	logic            fd_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			y_q     <= cy_q - YW'(r_eff);
			cyw_q   <= cy_q;
			wslot_q <= slot_q;
			fd_q    <= frame_done;
			if (last_col) begin
				x_q   <= (XW'(cx) >= XW'(r_eff)) ? cx - COLW'(r_eff) : '0;
				x_end_q <= cx;
			end else begin
				x_q   <= cx - COLW'(r_eff);
				x_end_q <= cx - COLW'(r_eff);
			end
		end else if (state_q == ST_OUT && !out_stall) begin
			x_q <= x_q + 1'b1;
		end
	end

	// line store
	logic [3*PIX_W-1:0] mem [DEPTH];
	logic [3*PIX_W-1:0] rdata_s1;
	logic [RW+COLW-1:0] rd_addr;

	always_ff @(posedge clk) begin
		if (accept && cy_q < h_eff) begin
			mem[{slot_q, cx}] <= {red, green, blue};
		end
		if (state_q == ST_READ) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// window tap walk
	logic [RW-1:0] i_q, j_q;
	logic signed [YW+1:0] row_s;
	logic signed [XW+1:0] col_s;
	logic [YW-1:0] row_c;
	logic [COLW-1:0] col_c;
	logic [RW-1:0] offs, rslot;
	logic tap_last, tap_ctr;

	always_comb begin
		row_s = $signed({2'b00, y_q}) + $signed({2'b00, YW'(i_q)}) - $signed({2'b00, YW'(r_eff)});
		if (row_s < 0) begin
			row_c = '0;
		end else if (row_s > $signed({2'b00, h_eff - 1'b1})) begin
			row_c = h_eff - 1'b1;
		end else begin
			row_c = row_s[YW-1:0];
		end
		col_s = $signed({2'b00, XW'(x_q)}) + $signed({2'b00, XW'(j_q)})
			- $signed({2'b00, XW'(r_eff)});
		if (col_s < 0) begin
			col_c = '0;
		end else if (col_s > $signed({2'b00, w_eff - 1'b1})) begin
			col_c = COLW'(w_eff - 1'b1);
		end else begin
			col_c = col_s[COLW-1:0];
		end
		offs  = RW'(cyw_q - row_c);
		rslot = (wslot_q >= offs) ? wslot_q - offs : RW'(32'(wslot_q) + LINE_ROWS - 32'(offs));
		rd_addr  = {rslot, col_c};
		tap_last = (RW'(i_q) == RW'(d_eff - 1'b1)) && (RW'(j_q) == RW'(d_eff - 1'b1));
		tap_ctr  = (i_q == r_eff) && (j_q == r_eff);
	end

	logic rd_vld_s1, rd_first_s1, rd_ctr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q       <= '0;
			j_q       <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_READ);
			if (state_q == ST_READ) begin
				if (tap_last) begin
					i_q <= '0;
					j_q <= '0;
				end else if (RW'(j_q) == RW'(d_eff - 1'b1)) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_first_s1 <= (i_q == '0) && (j_q == '0);
		rd_ctr_s1   <= tap_ctr;
	end

	// accumulate, weight, divide
	logic [SUMW-1:0]        acc_q [3];
	logic [PIX_W-1:0]       ctr_q [3];
	logic signed [PAW-1:0]  pa_q  [3];
	logic signed [PBW-1:0]  pb_q  [3];
	logic signed [NW-1:0]   num_q [3];
	logic [PIX_W-1:0]       quo   [3];
	logic [PIX_W-1:0]       res_q [3];
	logic [2:0]             done;
	logic signed [12:0]     cmo;

	assign cmo = $signed({cw_q[11], cw_q}) - $signed({ow_q[11], ow_q});

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (rd_vld_s1) begin
				acc_q[c] <= (rd_first_s1 ? '0 : acc_q[c])
					+ SUMW'(rdata_s1[(2-c)*PIX_W +: PIX_W]);
				if (rd_ctr_s1) begin
					ctr_q[c] <= rdata_s1[(2-c)*PIX_W +: PIX_W];
				end
			end
			if (state_q == ST_MUL) begin
				pa_q[c] <= PAW'($signed(ow_q) * $signed({1'b0, acc_q[c]}));
				pb_q[c] <= PBW'(cmo * $signed({1'b0, ctr_q[c]}));
			end
			if (state_q == ST_SUM) begin
				num_q[c] <= NW'(pa_q[c]) + NW'(pb_q[c]);
			end
			if (state_q == ST_DIV && done[0]) begin
				res_q[c] <= quo[c];
			end
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_div
		rwc_div #(.NW(NW), .DW(MSW)) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (state_q == ST_START),
			.num    (num_q[c]),
			.den    (msum_q),
			.quo    (quo[c]),
			.done   (done[c])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept && emit_any) state_d = ST_READ;
			ST_READ:  if (tap_last) state_d = ST_WAIT;
			ST_WAIT:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_SUM;
			ST_SUM:   state_d = ST_START;
			ST_START: state_d = ST_DIV;
			ST_DIV:   if (done[0]) state_d = ST_OUT;
			ST_OUT: begin
				if (!out_stall) state_d = (x_q == x_end_q) ? ST_IDLE : ST_READ;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	assign out_valid   = (state_q == ST_OUT);
	assign out_red     = res_q[0];
	assign out_green   = res_q[1];
	assign out_blue    = res_q[2];
	assign last_in_run = (x_q == x_end_q);
	assign frame_end   = fd_q && (x_q == x_end_q);

	assert property (@(posedge clk) disable iff (!arst_n) !in_stall |-> !out_valid)
		else $error("input taken while a result is pending");
	assert property (@(posedge clk) disable iff (!arst_n) rd_vld_s1 |-> $past(state_q) == ST_READ)
		else $error("read data tagged valid without a read");
	assert property (@(posedge clk) disable iff (!arst_n) done[0] |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> (i_q <= r_eff + r_eff) && (j_q <= r_eff + r_eff))
		else $error("window tap index out of range");
	assert property (@(posedge clk) disable iff (!arst_n) done[0] |-> done[1] && done[2])
		else $error("channel dividers out of step");

endmodule
